// File: src/nmqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmqr_pkg
// Shared widths, types and the texel byte decoder for the normal-map quad
// reduction pipeline.
// ----------------------------------------------------------------------------
package nmqr_pkg;

  localparam int BYTE_W  = 8;
  localparam int COMP_W  = 16;   // Q1.15 component
  localparam int SQ_W    = 30;   // square of one component
  localparam int ZROOT_W = 15;   // rebuilt z
  localparam int SUM_W   = 18;   // signed Q3.15 sum
  localparam int SZ_W    = 17;   // unsigned z sum
  localparam int SSQ_W   = 34;   // square of one sum
  localparam int L2_W    = 36;   // squared length
  localparam int LEN_W   = 18;   // length
  localparam int DEN_W   = LEN_W + 1;
  localparam int NUM_W   = DEN_W + BYTE_W;
  localparam int TEXELS  = 4;

  localparam logic [BYTE_W-1:0] PACK_MID = 8'd127;
  localparam logic [SQ_W:0]     ONE_SQ   = 31'd1 << 30;

  // ceil(2^31 / 255); exact floor division by 255 for dividends below 2^23
  localparam logic [46:0]       RECIP_255 = 47'd8421505;
  localparam int                RECIP_SH  = 31;

  typedef logic [BYTE_W-1:0]        byte_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // b in 0..255 maps to -1..1; magnitude rounded to nearest, saturated to Q1.15
  function automatic comp_t nmqr_decode(input byte_t b);
    logic signed [9:0] d;
    logic [7:0]        mag;
    logic [22:0]       x;
    logic [46:0]       p;
    logic [15:0]       q;
    logic [14:0]       qs;
    d   = $signed({1'b0, b, 1'b0}) - 10'sd255;
    mag = d[9] ? 8'(-d) : d[7:0];
    x   = {mag, 15'd0} + 23'd127;
    p   = 47'(x) * RECIP_255;
    q   = 16'(p >> RECIP_SH);
    qs  = (q > 16'd32767) ? 15'h7fff : q[14:0];
    return d[9] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  endfunction

endpackage

// File: src/nmqr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmqr_in_if
// Quad channel: four texels, x and y bytes each.
// ----------------------------------------------------------------------------
interface nmqr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] top_left_x;
  logic [7:0] top_left_y;
  logic [7:0] top_right_x;
  logic [7:0] top_right_y;
  logic [7:0] bottom_left_x;
  logic [7:0] bottom_left_y;
  logic [7:0] bottom_right_x;
  logic [7:0] bottom_right_y;

  modport source (
    output valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
    input  ready
  );
  modport sink (
    input  valid, top_left_x, top_left_y, top_right_x, top_right_y,
           bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
    output ready
  );
endinterface

// File: src/nmqr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmqr_out_if
// Result channel: packed x and y bytes of the reduced normal.
// ----------------------------------------------------------------------------
interface nmqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_x;
  logic [7:0] out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink (input valid, out_x, out_y, output ready);
endinterface

// File: src/nmqr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmqr_isqrt
// Pipelined integer square root, one root bit per stage, LANES in parallel,
// with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module nmqr_isqrt #(
  parameter int LANES = 4,
  parameter int OW    = 15,
  parameter int SW    = 36
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][2*OW-1:0]     in_rad,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [LANES-1:0][OW-1:0]       out_root,
  output logic [SW-1:0]                  out_side
);

  logic [OW-1:0]                  vld_r;
  logic [LANES-1:0][2*OW-1:0]     rad_r  [OW];
  logic [LANES-1:0][OW-1:0]       rem_r  [OW];
  logic [LANES-1:0][OW-1:0]       root_r [OW];
  logic [SW-1:0]                  side_r [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic                       vld_c;
    logic [LANES-1:0][2*OW-1:0] rad_c, rad_nxt;
    logic [LANES-1:0][OW-1:0]   rem_c, rem_nxt, root_c, root_nxt;
    logic [SW-1:0]              side_c;

    if (k == 0) begin : g_first
      assign vld_c  = in_valid;
      assign rad_c  = in_rad;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = in_side;
    end else begin : g_next
      assign vld_c  = vld_r[k-1];
      assign rad_c  = rad_r[k-1];
      assign rem_c  = rem_r[k-1];
      assign root_c = root_r[k-1];
      assign side_c = side_r[k-1];
    end

    always_comb begin
      logic [OW+1:0] rem2;
      logic [OW+1:0] trial;
      logic          ge;
      for (int i = 0; i < LANES; i++) begin
        rem2        = {rem_c[i], rad_c[i][2*OW-1:2*OW-2]};
        trial       = {root_c[i], 2'b01};
        ge          = (rem2 >= trial);
        rem_nxt[i]  = ge ? OW'(rem2 - trial) : OW'(rem2);
        root_nxt[i] = {root_c[i][OW-2:0], ge};
        rad_nxt[i]  = {rad_c[i][2*OW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = vld_r[OW-1];
  assign out_root  = root_r[OW-1];
  assign out_side  = side_r[OW-1];

endmodule

// File: src/nmqr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmqr_div
// Pipelined restoring divider, one quotient bit per stage, LANES sharing one
// divisor. Quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module nmqr_div #(
  parameter int LANES = 2,
  parameter int QW    = 8,
  parameter int NW    = 27,
  parameter int DW    = 19,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  logic [QW-1:0]                vld_r;
  logic [LANES-1:0][NW-1:0]     num_r  [QW];
  logic [LANES-1:0][QW-1:0]     quo_r  [QW];
  logic [DW-1:0]                den_r  [QW];
  logic [SW-1:0]                side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     vld_c;
    logic [LANES-1:0][NW-1:0] num_c, num_nxt;
    logic [LANES-1:0][QW-1:0] quo_c, quo_nxt;
    logic [DW-1:0]            den_c;
    logic [SW-1:0]            side_c;
    logic [NW-1:0]            den_sh;

    if (k == 0) begin : g_first
      assign vld_c  = in_valid;
      assign num_c  = in_num;
      assign quo_c  = '0;
      assign den_c  = in_den;
      assign side_c = in_side;
    end else begin : g_next
      assign vld_c  = vld_r[k-1];
      assign num_c  = num_r[k-1];
      assign quo_c  = quo_r[k-1];
      assign den_c  = den_r[k-1];
      assign side_c = side_r[k-1];
    end

    assign den_sh = NW'(den_c) << (QW - 1 - k);

    always_comb begin
      logic ge;
      for (int i = 0; i < LANES; i++) begin
        ge         = (num_c[i] >= den_sh);
        num_nxt[i] = ge ? num_c[i] - den_sh : num_c[i];
        quo_nxt[i] = {quo_c[i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k]  <= num_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_c;
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: src/normal_mip_quad_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_mip_quad_reduce
// 2x2 normal-map mip reduction: decodes four x/y texels, rebuilds z, sums,
// renormalizes and packs the result back to x and y bytes.
//
// Usage:
//   in_quad  : valid/ready channel, one 2x2 quad per transaction.
//   out_res  : valid/ready channel, one packed x/y pair per transaction.
//   Throughput is one quad per cycle while out_res is not stalling. From an
//   accepted quad to out_res.valid, the registered steps are: decode, squares
//   and radicand, z square root (one bit per stage), z sum, sum squares and
//   length squared, length square root, numerator setup, pack divide (one
//   quotient bit per stage) and the output register.
//   The whole pipeline advances when the output register is empty or being
//   taken; while out_res stalls with a result held, in_quad.ready is low and
//   every stage holds, so nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; payload registers are
//   not reset. A zero sum vector gives 127,127.
// ----------------------------------------------------------------------------
module normal_mip_quad_reduce (
  input  logic           clk,
  input  logic           rst_n,
  nmqr_in_if.sink        in_quad,
  nmqr_out_if.source     out_res
);
  import nmqr_pkg::*;

  logic en;

  logic [TEXELS-1:0][BYTE_W-1:0] bx, by;

  // stage 1: decode
  logic                  s1_vld_r;
  comp_t                 s1_x_r [TEXELS];
  comp_t                 s1_y_r [TEXELS];
  // stage 2: squares
  logic                  s2_vld_r;
  comp_t                 s2_x_r [TEXELS];
  comp_t                 s2_y_r [TEXELS];
  logic [SQ_W-1:0]       s2_x2_r [TEXELS];
  logic [SQ_W-1:0]       s2_y2_r [TEXELS];
  // stage 3: radicand and x/y sums
  logic                  s3_vld_r;
  logic [TEXELS-1:0][SQ_W-1:0] s3_rad_r;
  sum_t                  s3_sx_r, s3_sy_r;
  sum_t                  s3_sx_nxt, s3_sy_nxt;
  logic [TEXELS-1:0][SQ_W-1:0] s3_rad_nxt;

  logic                  zq_vld;
  logic [TEXELS-1:0][ZROOT_W-1:0] zq_root;
  logic [2*SUM_W-1:0]    zq_side;

  // stage 4: z sum
  logic                  s4_vld_r;
  sum_t                  s4_sx_r, s4_sy_r;
  logic [SZ_W-1:0]       s4_sz_r;
  // stage 5: squares of sums
  logic                  s5_vld_r;
  sum_t                  s5_sx_r, s5_sy_r;
  logic [SSQ_W-1:0]      s5_sx2_r, s5_sy2_r, s5_sz2_r;
  // stage 6: length squared
  logic                  s6_vld_r;
  sum_t                  s6_sx_r, s6_sy_r;
  logic [L2_W-1:0]       s6_l2_r;

  logic                  lq_vld;
  logic [0:0][LEN_W-1:0] lq_root;
  logic [2*SUM_W-1:0]    lq_side;
  sum_t                  lq_sx, lq_sy;

  // stage 7: numerators and divisor
  logic                  s7_vld_r;
  logic [1:0][NUM_W-1:0] s7_num_r;
  logic [DEN_W-1:0]      s7_den_r;
  logic                  s7_zero_r;
  logic [DEN_W:0]        s7_ax, s7_ay;

  logic                  dq_vld;
  logic [1:0][BYTE_W-1:0] dq_quo;
  logic                  dq_zero;

  // output register
  logic                  out_vld_r;
  byte_t                 out_x_r, out_y_r;

  assign en            = !out_vld_r || out_res.ready;
  assign in_quad.ready = en;

  assign bx = {in_quad.bottom_right_x, in_quad.bottom_left_x,
               in_quad.top_right_x, in_quad.top_left_x};
  assign by = {in_quad.bottom_right_y, in_quad.bottom_left_y,
               in_quad.top_right_y, in_quad.top_left_y};

  always_comb begin
    logic [SQ_W:0] sq;
    s3_sx_nxt = '0;
    s3_sy_nxt = '0;
    for (int t = 0; t < TEXELS; t++) begin
      sq            = {1'b0, s2_x2_r[t]} + {1'b0, s2_y2_r[t]};
      s3_rad_nxt[t] = (sq >= ONE_SQ) ? '0 : SQ_W'(ONE_SQ - sq);
      s3_sx_nxt     = s3_sx_nxt + SUM_W'(s2_x_r[t]);
      s3_sy_nxt     = s3_sy_nxt + SUM_W'(s2_y_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_quad.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= zq_vld;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= lq_vld;
      out_vld_r <= dq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < TEXELS; t++) begin
        s1_x_r[t]  <= nmqr_decode(bx[t]);
        s1_y_r[t]  <= nmqr_decode(by[t]);
        s2_x_r[t]  <= s1_x_r[t];
        s2_y_r[t]  <= s1_y_r[t];
        s2_x2_r[t] <= SQ_W'(unsigned'(32'(s1_x_r[t]) * 32'(s1_x_r[t])));
        s2_y2_r[t] <= SQ_W'(unsigned'(32'(s1_y_r[t]) * 32'(s1_y_r[t])));
      end
      s3_rad_r <= s3_rad_nxt;
      s3_sx_r  <= s3_sx_nxt;
      s3_sy_r  <= s3_sy_nxt;
    end
  end

  nmqr_isqrt #(
    .LANES (TEXELS),
    .OW    (ZROOT_W),
    .SW    (2*SUM_W)
  ) u_zsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_rad_r),
    .in_side   ({s3_sx_r, s3_sy_r}),
    .out_valid (zq_vld),
    .out_root  (zq_root),
    .out_side  (zq_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sx_r  <= zq_side[2*SUM_W-1:SUM_W];
      s4_sy_r  <= zq_side[SUM_W-1:0];
      s4_sz_r  <= SZ_W'(zq_root[0]) + SZ_W'(zq_root[1])
                + SZ_W'(zq_root[2]) + SZ_W'(zq_root[3]);
      s5_sx_r  <= s4_sx_r;
      s5_sy_r  <= s4_sy_r;
      s5_sx2_r <= SSQ_W'(unsigned'(L2_W'(s4_sx_r) * L2_W'(s4_sx_r)));
      s5_sy2_r <= SSQ_W'(unsigned'(L2_W'(s4_sy_r) * L2_W'(s4_sy_r)));
      s5_sz2_r <= SSQ_W'(s4_sz_r) * SSQ_W'(s4_sz_r);
      s6_sx_r  <= s5_sx_r;
      s6_sy_r  <= s5_sy_r;
      s6_l2_r  <= L2_W'(s5_sx2_r) + L2_W'(s5_sy2_r) + L2_W'(s5_sz2_r);
    end
  end

  nmqr_isqrt #(
    .LANES (1),
    .OW    (LEN_W),
    .SW    (2*SUM_W)
  ) u_lsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_vld_r),
    .in_rad    (s6_l2_r),
    .in_side   ({s6_sx_r, s6_sy_r}),
    .out_valid (lq_vld),
    .out_root  (lq_root),
    .out_side  (lq_side)
  );

  assign lq_sx = lq_side[2*SUM_W-1:SUM_W];
  assign lq_sy = lq_side[SUM_W-1:0];

  // L + s lies in 0..2L
  assign s7_ax = (DEN_W+1)'($signed({2'b00, lq_root[0]}) + (DEN_W+1)'(lq_sx));
  assign s7_ay = (DEN_W+1)'($signed({2'b00, lq_root[0]}) + (DEN_W+1)'(lq_sy));

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num_r[0] <= NUM_W'(s7_ax[DEN_W-1:0]) * NUM_W'(8'd255);
      s7_num_r[1] <= NUM_W'(s7_ay[DEN_W-1:0]) * NUM_W'(8'd255);
      s7_den_r    <= {lq_root[0], 1'b0};
      s7_zero_r   <= (lq_root[0] == '0);
    end
  end

  nmqr_div #(
    .LANES (2),
    .QW    (BYTE_W),
    .NW    (NUM_W),
    .DW    (DEN_W),
    .SW    (1)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_vld_r),
    .in_num    (s7_num_r),
    .in_den    (s7_den_r),
    .in_side   (s7_zero_r),
    .out_valid (dq_vld),
    .out_quo   (dq_quo),
    .out_side  (dq_zero)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= dq_zero ? PACK_MID : dq_quo[0];
      out_y_r <= dq_zero ? PACK_MID : dq_quo[1];
    end
  end

  assign out_res.valid = out_vld_r;
  assign out_res.out_x = out_x_r;
  assign out_res.out_y = out_y_r;

endmodule

// File: tb/tb_normal_mip_quad_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_mip_quad_reduce
// Self-checking bench for the 2x2 normal-map quad reduction. Directed corner
// quads, then random bursts with a randomly stalling receiver; a scoreboard
// class predicts each packed x/y pair and checks results in order.
// ----------------------------------------------------------------------------
module tb_normal_mip_quad_reduce;
  import nmqr_pkg::*;

  typedef struct packed {
    logic [7:0] tlx, tly, trx, try_, blx, bly, brx, bry;
  } quad_t;

  typedef struct packed {
    logic [7:0] x, y;
  } texel_out_t;

  class quad_scoreboard;
    texel_out_t pending[$];
    int mismatches = 0;
    int orphans = 0;
    int checked = 0;

    function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic longint unpack_byte(logic [7:0] b);
      longint d, m, q;
      d = 2 * longint'(b) - 255;
      m = d < 0 ? -d : d;
      q = (m * 32768 + 127) / 255;
      if (q > 32767) q = 32767;
      return d < 0 ? -q : q;
    endfunction

    function automatic logic [7:0] repack(longint s, longint len);
      longint v;
      v = (255 * (len + s)) / (2 * len);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function automatic texel_out_t reduce(quad_t q);
      logic [7:0] b[8];
      longint sx, sy, sz, x, y, r, z, len;
      logic [63:0] l2;
      texel_out_t o;
      b = '{q.tlx, q.tly, q.trx, q.try_, q.blx, q.bly, q.brx, q.bry};
      sx = 0; sy = 0; sz = 0;
      for (int k = 0; k < 4; k++) begin
        x = unpack_byte(b[2*k]);
        y = unpack_byte(b[2*k+1]);
        r = (longint'(1) << 30) - x * x - y * y;
        if (r < 0) r = 0;
        z = longint'(root64(r));
        if (z > 32767) z = 32767;
        sx += x; sy += y; sz += z;
      end
      l2 = sx * sx + sy * sy + sz * sz;
      if (l2 == 0) begin
        o.x = 8'd127; o.y = 8'd127;
      end else begin
        len = longint'(root64(l2));
        o.x = repack(sx, len);
        o.y = repack(sy, len);
      end
      return o;
    endfunction

    function void note_quad(quad_t q);
      pending.push_back(reduce(q));
    endfunction

    function void check_result(logic [7:0] x, logic [7:0] y);
      texel_out_t e;
      if (pending.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10) $display("unexpected result x=%0d y=%0d", x, y);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.x !== x || e.y !== y) begin
        mismatches++;
        if (mismatches + orphans <= 10)
          $display("mismatch #%0d: exp x=%0d y=%0d got x=%0d y=%0d",
                   checked, e.x, e.y, x, y);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  nmqr_in_if  in_quad();
  nmqr_out_if out_res();

  normal_mip_quad_reduce dut (.clk(clk), .rst_n(rst_n), .in_quad(in_quad), .out_res(out_res));

  quad_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit hold_long = 0;
  bit stim_done = 0;

  initial begin
    in_quad.valid = 0;
    {in_quad.top_left_x, in_quad.top_left_y, in_quad.top_right_x, in_quad.top_right_y,
     in_quad.bottom_left_x, in_quad.bottom_left_y, in_quad.bottom_right_x,
     in_quad.bottom_right_y} = '0;
    out_res.ready = 0;
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_quad.valid && in_quad.ready)
        sb.note_quad({in_quad.top_left_x, in_quad.top_left_y, in_quad.top_right_x,
                      in_quad.top_right_y, in_quad.bottom_left_x, in_quad.bottom_left_y,
                      in_quad.bottom_right_x, in_quad.bottom_right_y});
      if (out_res.valid && out_res.ready) sb.check_result(out_res.out_x, out_res.out_y);
      if ((in_quad.valid && in_quad.ready) || (out_res.valid && out_res.ready) ||
          (stim_done && sb.pending.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_res.ready <= 0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      mode = ($urandom_range(0, 199) < 20) ? 0 : 1;
      if (mode == 0) out_res.ready <= 1;
      else out_res.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_quad(quad_t q);
    in_quad.valid <= 1;
    {in_quad.top_left_x, in_quad.top_left_y, in_quad.top_right_x, in_quad.top_right_y,
     in_quad.bottom_left_x, in_quad.bottom_left_y, in_quad.bottom_right_x,
     in_quad.bottom_right_y} <= q;
    do @(posedge clk); while (!in_quad.ready);
    sent++;
  endtask

  task automatic pause_sender(int n);
    in_quad.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic quad_t rand_quad();
    quad_t q;
    logic [7:0] b[8];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      if (kind < 5) b[i] = $urandom_range(0, 255);
      else if (kind < 8) b[i] = $urandom_range(100, 155);   // x and y near zero (near +z normals)
      else b[i] = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ ($urandom_range(0, 1) ? 8'd1 : 8'd0);
    end
    q = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    return q;
  endfunction

  initial begin
    int burst;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners
    send_quad('0);
    send_quad('1);
    send_quad({8{8'd127}});
    send_quad({8{8'd128}});
    send_quad({8'd0, 8'd127, 8'd255, 8'd127, 8'd127, 8'd0, 8'd127, 8'd255}); // opposing x and y pairs
    send_quad({8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0});
    send_quad({8'd255, 8'd128, 8'd255, 8'd128, 8'd255, 8'd128, 8'd255, 8'd128});
    send_quad({8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128});
    send_quad({8'd128, 8'd255, 8'd128, 8'd255, 8'd128, 8'd255, 8'd128, 8'd255});
    send_quad({8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0});
    send_quad({8'd200, 8'd200, 8'd200, 8'd200, 8'd56, 8'd56, 8'd56, 8'd56});
    send_quad({8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55});
    send_quad({8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 8'd254, 8'd1, 8'd254});
    // long receiver hold while the sender keeps offering
    hold_long = 1;
    for (int i = 0; i < 80; i++) send_quad(rand_quad());
    // sender waits for the pipeline to drain
    in_quad.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (sent < 1350) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_quad(rand_quad());
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
    end
    in_quad.valid <= 0;
    stim_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d quads: corner bytes, zero sum, clamped radicands, random bursts",
             sent);
    $display("results checked %0d, mismatches %0d, unexpected %0d",
             sb.checked, sb.mismatches, sb.orphans);
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
